FILE: hdl/pitt_pkg.sv
package pitt_pkg;

    localparam int NUM_VERTS = 3;
    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int EDGE_W    = PROD_W + 1;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic        [EDGE_W-1:0]  t_edge;
    typedef logic        [CFG_IDX_W-1:0] t_cfg_idx;

    // side of a point relative to an edge: zero, positive or negative
    typedef struct packed {
        logic nz;
        logic neg;
    } t_side;

    localparam t_cfg_idx REG_AX = 3'd0;
    localparam t_cfg_idx REG_AY = 3'd1;
    localparam t_cfg_idx REG_BX = 3'd2;
    localparam t_cfg_idx REG_BY = 3'd3;
    localparam t_cfg_idx REG_CX = 3'd4;
    localparam t_cfg_idx REG_CY = 3'd5;

    function automatic t_diff sub_ext(input t_coord a, input t_coord b);
        t_diff ea;
        t_diff eb;
        ea = {a[COORD_W-1], a};
        eb = {b[COORD_W-1], b};
        return ea - eb;
    endfunction

endpackage

FILE: hdl/point_in_triangle_test_unit.sv
// Pipeline: 4 register stages; a transferred point moves through the offset,
// product and edge numerator registers and then into the output register.
// Throughput: one point per cycle; the 4-stage pipeline (offsets, products,
// edge numerators, side compare) holds as a whole only while a finished
// result is stalled at the output.
// Reset: synchronous, active low; clears the valid bits and all six vertex
// registers to zero.
module point_in_triangle_test_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic signed [15:0]     i_point_x,
    input  logic signed [15:0]     i_point_y,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_inside_res,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  pitt_pkg::t_cfg_idx     i_cfg_index,
    input  logic [15:0]            i_cfg_data
);
    import pitt_pkg::*;

    t_coord r_vx [NUM_VERTS];
    t_coord r_vy [NUM_VERTS];

    logic r_v1, r_v2, r_v3, r_out_v;
    logic r_inside;
    logic ce;

    // per-edge pipeline registers
    t_diff r1_dx [NUM_VERTS];
    t_diff r1_dy [NUM_VERTS];
    t_diff r1_qx [NUM_VERTS];
    t_diff r1_qy [NUM_VERTS];
    t_diff r1_kx [NUM_VERTS];
    t_diff r1_ky [NUM_VERTS];

    t_prod r2_pa [NUM_VERTS];
    t_prod r2_pb [NUM_VERTS];
    t_prod r2_va [NUM_VERTS];
    t_prod r2_vb [NUM_VERTS];
    t_diff r2_dx [NUM_VERTS];
    t_side r2_pvert [NUM_VERTS];
    t_side r2_vvert [NUM_VERTS];

    t_edge r3_ep [NUM_VERTS];
    t_edge r3_ev [NUM_VERTS];
    t_diff r3_dx [NUM_VERTS];
    t_side r3_pvert [NUM_VERTS];
    t_side r3_vvert [NUM_VERTS];

    logic [NUM_VERTS-1:0] reject;
    logic                 n_inside;

    assign ce           = !r_out_v || !i_out_stall;
    assign o_in_stall   = !ce;
    assign o_out_valid  = r_out_v;
    assign o_inside_res = r_inside;
    assign o_cfg_ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < NUM_VERTS; v++) begin
                r_vx[v] <= '0;
                r_vy[v] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_AX:  r_vx[0] <= i_cfg_data;
                REG_AY:  r_vy[0] <= i_cfg_data;
                REG_BX:  r_vx[1] <= i_cfg_data;
                REG_BY:  r_vy[1] <= i_cfg_data;
                REG_CX:  r_vx[2] <= i_cfg_data;
                REG_CY:  r_vy[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (ce) begin
            r_v1    <= i_in_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_out_v <= r_v3;
        end
    end

    for (genvar e = 0; e < NUM_VERTS; e++) begin : g_edge
        localparam int F = e;
        localparam int T = (e + 1) % NUM_VERTS;
        localparam int K = (e + 2) % NUM_VERTS;

        logic [EDGE_W-1:0] abs_ep, abs_ev;
        logic [DIFF_W-1:0] abs_dx;
        t_side             side_p, side_v;
        logic              dx_zero;

        always_ff @(posedge i_clk) begin
            if (ce) begin
                // stage 1: offsets from the edge's end vertex
                r1_dx[e] <= sub_ext(r_vx[T], r_vx[F]);
                r1_dy[e] <= sub_ext(r_vy[T], r_vy[F]);
                r1_qx[e] <= sub_ext(i_point_x, r_vx[T]);
                r1_qy[e] <= sub_ext(i_point_y, r_vy[T]);
                r1_kx[e] <= sub_ext(r_vx[K], r_vx[T]);
                r1_ky[e] <= sub_ext(r_vy[K], r_vy[T]);
                // stage 2: cross products
                r2_pa[e]        <= PROD_W'(r1_qy[e]) * PROD_W'(r1_dx[e]);
                r2_pb[e]        <= PROD_W'(r1_dy[e]) * PROD_W'(r1_qx[e]);
                r2_va[e]        <= PROD_W'(r1_ky[e]) * PROD_W'(r1_dx[e]);
                r2_vb[e]        <= PROD_W'(r1_dy[e]) * PROD_W'(r1_kx[e]);
                r2_dx[e]        <= r1_dx[e];
                r2_pvert[e].nz  <= |r1_qx[e];
                r2_pvert[e].neg <= r1_qx[e][DIFF_W-1];
                r2_vvert[e].nz  <= |r1_kx[e];
                r2_vvert[e].neg <= r1_kx[e][DIFF_W-1];
                // stage 3: edge numerators
                r3_ep[e]    <= {r2_pa[e][PROD_W-1], r2_pa[e]} - {r2_pb[e][PROD_W-1], r2_pb[e]};
                r3_ev[e]    <= {r2_va[e][PROD_W-1], r2_va[e]} - {r2_vb[e][PROD_W-1], r2_vb[e]};
                r3_dx[e]    <= r2_dx[e];
                r3_pvert[e] <= r2_pvert[e];
                r3_vvert[e] <= r2_vvert[e];
            end
        end

        // stage 4: with dx zero, side is that of the x offset; else zero when |E| < |dx|, else sign(E)*sign(dx)
        always_comb begin
            dx_zero = ~|r3_dx[e];
            abs_dx  = r3_dx[e][DIFF_W-1] ? DIFF_W'(-r3_dx[e]) : r3_dx[e];
            abs_ep  = r3_ep[e][EDGE_W-1] ? (~r3_ep[e] + EDGE_W'(1)) : r3_ep[e];
            abs_ev  = r3_ev[e][EDGE_W-1] ? (~r3_ev[e] + EDGE_W'(1)) : r3_ev[e];
            if (dx_zero) begin
                side_p = r3_pvert[e];
                side_v = r3_vvert[e];
            end else begin
                side_p.nz  = !(abs_ep < {{(EDGE_W-DIFF_W){1'b0}}, abs_dx});
                side_p.neg = r3_ep[e][EDGE_W-1] ^ r3_dx[e][DIFF_W-1];
                side_v.nz  = !(abs_ev < {{(EDGE_W-DIFF_W){1'b0}}, abs_dx});
                side_v.neg = r3_ev[e][EDGE_W-1] ^ r3_dx[e][DIFF_W-1];
            end
            reject[e] = side_p.nz && side_v.nz && (side_p.neg != side_v.neg);
        end
    end

    assign n_inside = ~|reject;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_inside <= n_inside;
        end
    end

`ifndef SYNTHESIS
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_out_stall) |-> o_in_stall)
        else $error("input taken while output result is stalled");

    a_enter_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v1)
        else $error("transferred point lost at pipeline entry");

    a_reach_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && ce) |=> r_out_v)
        else $error("last stage item did not reach the output register");
`endif

endmodule

FILE: test/point_in_triangle_test_unit_tb.sv
module point_in_triangle_test_unit_tb;

    import pitt_pkg::*;

    // indexes past the vertex registers: writes there must change nothing
    localparam t_cfg_idx REG_SPARE0 = 3'd6;
    localparam t_cfg_idx REG_SPARE1 = 3'd7;

    localparam int LATENCY         = 4;
    localparam int DRAIN_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int PRESSURE_CYCLES = 100;
    localparam int RAND_PHASES     = 8;
    localparam int POINTS_PER_PHASE = 50;

    typedef enum logic {ROW_WRITE, ROW_POINT} t_row_kind;
    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} t_stall_mode;

    typedef struct packed {
        t_row_kind   kind;
        t_cfg_idx    idx;
        logic [15:0] data;
        t_coord      px;
        t_coord      py;
        logic        typed;
        logic        res;
    } t_row;

    typedef struct packed {
        t_coord px;
        t_coord py;
        logic   res;
    } t_expect;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_coord      i_point_x;
    t_coord      i_point_y;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_inside_res;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index;
    logic [15:0] i_cfg_data;

    t_row    plan[$];
    t_expect pending_inside[$];
    t_coord  vert_x[NUM_VERTS];
    t_coord  vert_y[NUM_VERTS];
    int      fails = 0;
    int      cycles = 0;
    int      burst_left = 0;
    bit      hold_req = 1'b0;

    point_in_triangle_test_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_inside_res (o_inside_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int sign_of(longint v);
        if (v > 0) return 1;
        if (v < 0) return -1;
        return 0;
    endfunction

    // side of (qx,qy) for the edge f->t; zero means "on or too close to call"
    function automatic int edge_side_of(longint fx, longint fy, longint tx, longint ty,
                                        longint qx, longint qy);
        longint dx;
        longint dy;
        longint num;
        longint anum;
        longint adx;
        dx = tx - fx;
        dy = ty - fy;
        if (dx == 0) return sign_of(qx - tx);
        num  = (qy - ty) * dx - dy * (qx - tx);
        anum = (num < 0) ? -num : num;
        adx  = (dx < 0) ? -dx : dx;
        if (anum < adx) return 0;
        return sign_of(num) * sign_of(dx);
    endfunction

    function automatic logic point_inside(t_coord px, t_coord py);
        int   j;
        int   k;
        int   s_pt;
        int   s_opp;
        logic in_tri;
        in_tri = 1'b1;
        for (int i = 0; i < NUM_VERTS; i++) begin
            j = (i + 1) % NUM_VERTS;
            k = (i + 2) % NUM_VERTS;
            s_pt  = edge_side_of(vert_x[i], vert_y[i], vert_x[j], vert_y[j], px, py);
            s_opp = edge_side_of(vert_x[i], vert_y[i], vert_x[j], vert_y[j],
                                 vert_x[k], vert_y[k]);
            if (s_pt != 0 && s_opp != 0 && s_pt != s_opp) in_tri = 1'b0;
        end
        return in_tri;
    endfunction

    function automatic int pick_coord(int span);
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            2: return int'($urandom_range(0, 65535)) - 32768;
            default: return int'($urandom_range(0, 2 * span)) - span;
        endcase
    endfunction

    task automatic add_cfg(t_cfg_idx idx, int v);
        t_row r;
        r = '0;
        r.kind = ROW_WRITE;
        r.idx  = idx;
        r.data = v[15:0];
        plan.push_back(r);
    endtask

    task automatic add_pt(int x, int y, logic typed, logic res);
        t_row r;
        r = '0;
        r.kind  = ROW_POINT;
        r.px    = x[15:0];
        r.py    = y[15:0];
        r.typed = typed;
        r.res   = res;
        plan.push_back(r);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_AX: vert_x[0] = data;
            REG_AY: vert_y[0] = data;
            REG_BX: vert_x[1] = data;
            REG_BY: vert_y[1] = data;
            REG_CX: vert_x[2] = data;
            REG_CY: vert_y[2] = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // bursts of back-to-back transfers separated by random gaps
    task automatic send_point(t_coord px, t_coord py, logic typed, logic res);
        int      gap;
        t_expect want;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_point_x  <= px;
        i_point_y  <= py;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want.px  = px;
        want.py  = py;
        want.res = typed ? res : point_inside(px, py);
        pending_inside.push_back(want);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_inside.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic random_triangle(int span);
        write_reg(REG_AX, 16'(pick_coord(span)));
        write_reg(REG_AY, 16'(pick_coord(span)));
        write_reg(REG_BX, 16'(pick_coord(span)));
        write_reg(REG_BY, 16'(pick_coord(span)));
        write_reg(REG_CX, 16'(pick_coord(span)));
        write_reg(REG_CY, 16'(pick_coord(span)));
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE1 : REG_SPARE0,
                      16'($urandom_range(0, 65535)));
    endtask

    // stimulus and end of run
    initial begin
        bit busy;
        int minx;
        int maxx;
        int miny;
        int maxy;
        int px;
        int py;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_point_x   = '0;
        i_point_y   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_AX;
        i_cfg_data  = '0;
        busy        = 1'b0;
        for (int i = 0; i < NUM_VERTS; i++) begin
            vert_x[i] = '0;
            vert_y[i] = '0;
        end

        // all vertices at the origin after reset: every edge is skipped
        add_pt(0, 0, 1'b1, 1'b1);
        add_pt(32767, -32768, 1'b1, 1'b1);
        add_pt(-32768, 32767, 1'b1, 1'b1);
        // right triangle, plus writes to unused indexes
        add_cfg(REG_AX, 0);   add_cfg(REG_AY, 0);
        add_cfg(REG_BX, 100); add_cfg(REG_BY, 0);
        add_cfg(REG_CX, 0);   add_cfg(REG_CY, 100);
        add_cfg(REG_SPARE0, 7); add_cfg(REG_SPARE1, -1);
        add_pt(10, 10, 1'b0, 1'b0);
        add_pt(200, 200, 1'b0, 1'b0);
        add_pt(-1, 5, 1'b0, 1'b0);
        add_pt(50, 50, 1'b0, 1'b0);
        add_pt(0, 0, 1'b0, 1'b0);
        // full-range triangle
        add_cfg(REG_AX, -32768); add_cfg(REG_AY, -32768);
        add_cfg(REG_BX, 32767);  add_cfg(REG_BY, -32768);
        add_cfg(REG_CX, -32768); add_cfg(REG_CY, 32767);
        add_pt(0, 0, 1'b0, 1'b0);
        add_pt(32767, 32767, 1'b0, 1'b0);
        add_pt(-32768, -32768, 1'b0, 1'b0);
        add_pt(-1, -1, 1'b0, 1'b0);
        // vertical edge A->B
        add_cfg(REG_AX, 0);  add_cfg(REG_AY, 0);
        add_cfg(REG_BX, 0);  add_cfg(REG_BY, 100);
        add_cfg(REG_CX, 50); add_cfg(REG_CY, 50);
        add_pt(10, 50, 1'b0, 1'b0);
        add_pt(-10, 50, 1'b0, 1'b0);
        add_pt(0, 200, 1'b0, 1'b0);
        // coincident vertices: nothing rejects
        add_cfg(REG_AX, 5); add_cfg(REG_AY, 5);
        add_cfg(REG_BX, 5); add_cfg(REG_BY, 5);
        add_cfg(REG_CX, 5); add_cfg(REG_CY, 5);
        add_pt(-32768, -32768, 1'b1, 1'b1);
        add_pt(32767, 32767, 1'b1, 1'b1);
        // collinear vertices
        add_cfg(REG_BX, 10); add_cfg(REG_BY, 10);
        add_cfg(REG_CX, 20); add_cfg(REG_CY, 20);
        add_cfg(REG_AX, 0);  add_cfg(REG_AY, 0);
        add_pt(5, 5, 1'b0, 1'b0);
        add_pt(5, 6, 1'b0, 1'b0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            if (plan[n].kind == ROW_WRITE) begin
                if (busy) begin
                    wait_idle();
                    busy = 1'b0;
                end
                write_reg(plan[n].idx, plan[n].data);
            end else begin
                send_point(plan[n].px, plan[n].py, plan[n].typed, plan[n].res);
                busy = 1'b1;
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            random_triangle((ph % 2 == 1) ? 32768 : 300);
            minx = vert_x[0]; maxx = vert_x[0];
            miny = vert_y[0]; maxy = vert_y[0];
            for (int i = 1; i < NUM_VERTS; i++) begin
                if (vert_x[i] < minx) minx = vert_x[i];
                if (vert_x[i] > maxx) maxx = vert_x[i];
                if (vert_y[i] < miny) miny = vert_y[i];
                if (vert_y[i] > maxy) maxy = vert_y[i];
            end
            for (int n = 0; n < POINTS_PER_PHASE; n++) begin
                // long output hold-off while points keep coming
                if (ph == 3 && n == 5) hold_req = 1'b1;
                if ($urandom_range(0, 4) == 0) begin
                    px = int'($urandom_range(0, 65535)) - 32768;
                    py = int'($urandom_range(0, 65535)) - 32768;
                end else begin
                    px = minx - 4 + int'($urandom_range(0, maxx - minx + 8));
                    py = miny - 4 + int'($urandom_range(0, maxy - miny + 8));
                end
                send_point(px[15:0], py[15:0], 1'b0, 1'b0);
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_inside.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0 && pending_inside.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // output stall pattern, with one long hold-off on request
    initial begin
        t_stall_mode mode;
        int          mode_left;
        int          hold;
        i_out_stall = 1'b0;
        mode        = STALL_NONE;
        mode_left   = 40;
        hold        = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold = PRESSURE_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_out_stall <= ~i_out_stall;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_result
        t_expect want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_inside.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result transfer: inside=%0b", o_inside_res);
            end else begin
                want = pending_inside.pop_front();
                if (o_inside_res !== want.res) begin
                    fails++;
                    if (fails <= 10)
                        $display("mismatch at point (%0d,%0d): expected inside=%0b, got %0b",
                                 want.px, want.py, want.res, o_inside_res);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

FILE: point_in_triangle_test_unit.f
hdl/pitt_pkg.sv
hdl/point_in_triangle_test_unit.sv
test/point_in_triangle_test_unit_tb.sv
